[src/ues_pkg.sv]
package ues_pkg;

  localparam logic RECORD_PART = 1'b0;
  localparam logic RECORD_END  = 1'b1;

  localparam int NUM_SINGLE = 22;
  localparam int NUM_RANGE  = 13;

  localparam logic [20:0] SINGLE_LIST [NUM_SINGLE] = '{
    21'h000A9, 21'h000AE, 21'h0203C, 21'h02049, 21'h020E3, 21'h02122, 21'h02139, 21'h0231A,
    21'h0231B, 21'h02328, 21'h023CF, 21'h024C2, 21'h025AA, 21'h025AB, 21'h025B6, 21'h025C0,
    21'h02934, 21'h02935, 21'h03030, 21'h0303D, 21'h03297, 21'h03299
  };

  localparam logic [20:0] RANGE_LO [NUM_RANGE] = '{
    21'h02194, 21'h021A9, 21'h023E9, 21'h023F8, 21'h025FB, 21'h02600, 21'h02B00,
    21'h1F000, 21'h1F0A0, 21'h1F100, 21'h1F600, 21'h1F900, 21'h1F980
  };

  localparam logic [20:0] RANGE_HI [NUM_RANGE] = '{
    21'h02199, 21'h021AA, 21'h023F3, 21'h023FA, 21'h025FE, 21'h027EF, 21'h02BFF,
    21'h1F02F, 21'h1F0FF, 21'h1F64F, 21'h1F6FF, 21'h1F9FF, 21'h1F9E0
  };

  localparam logic [20:0] ZWJ_CP = 21'h0200D;
  localparam logic [20:0] VS15_CP = 21'h0FE0E;
  localparam logic [20:0] VS16_CP = 21'h0FE0F;

  // one entry per accepted byte that yields records
  typedef struct packed {
    logic        part_valid;
    logic [15:0] part_offset;
    logic        part_emoji;
    logic [15:0] part_number;
    logic        end_valid;
    logic [15:0] end_offset;
    logic [15:0] end_number;
  } event_t;

  function automatic logic classify_cp(input logic [20:0] cp, input logic run_emoji);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_SINGLE; k++) begin
      if (cp == SINGLE_LIST[k]) hit = 1'b1;
    end
    for (int k = 0; k < NUM_RANGE; k++) begin
      if (cp >= RANGE_LO[k] && cp <= RANGE_HI[k]) hit = 1'b1;
    end
    if (run_emoji && (cp == ZWJ_CP || cp == VS15_CP || cp == VS16_CP)) hit = 1'b1;
    return hit;
  endfunction

endpackage

[src/ues_in_if.sv]
interface ues_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

[src/ues_out_if.sv]
interface ues_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] byte_offset;
  logic        part_emoji;
  logic [15:0] part_number;
  logic        last_of_run;

  modport source (
    output valid, output record_kind, output byte_offset, output part_emoji,
    output part_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input record_kind, input byte_offset, input part_emoji,
    input part_number, input last_of_run, output ready
  );
endinterface

[src/utf8_emoji_run_segmenter_core.sv]
// channel | dir | payload
// in_i    | in  | text_byte[7:0], final_byte
// out_o   | out | record_kind, byte_offset[15:0], part_emoji, part_number[15:0], last_of_run
//
// One byte accepted per cycle; decode and classification are combinational in the front.
// Each byte yields 0..2 records; the back drains one record per cycle unless out_o stalls, so a
// byte with two records makes two transfers, absorbed by the QUEUE_DEPTH queue.
// A byte's first record passes through its queue entry, then the back's output register.
// Input stalls only when the queue is full. Reset is asynchronous and clears control state only.
module utf8_emoji_run_segmenter_core #(
  parameter int MAX_TEXT_BYTES = 65535,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ues_in_if.sink    in_i,
  ues_out_if.source out_o
);

  ues_pkg::event_t push_evt, head_evt;
  logic            push, pop, empty, full;

  ues_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .evt_o (push_evt)
  );

  ues_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_evt),
    .pop_i  (pop),
    .data_o (head_evt),
    .empty_o(empty),
    .full_o (full)
  );

  ues_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .out_o  (out_o),
    .head_i (head_evt),
    .empty_i(empty),
    .pop_o  (pop)
  );

endmodule

[src/ues_front.sv]
module ues_front #(
  parameter int MAX_TEXT_BYTES = 65535
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ues_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output ues_pkg::event_t evt_o
);

  localparam int CntW = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TEXT_BYTES);

  function automatic logic [15:0] sat16(input logic [CntW-1:0] v);
    logic [15:0] r;
    if (v > CntW'(17'h0FFFF)) r = 16'hFFFF;
    else r = 16'(v);
    return r;
  endfunction

  logic [CntW-1:0] bytes_seen_q, bytes_seen_d, cso_q, cso_d, cso_cur, bs_new;
  logic [1:0]      bytes_left_q, bytes_left_d;
  logic [20:0]     acc_q, acc_d, acc_new;
  logic            run_q, run_d, seen_q, seen_d;
  logic [15:0]     parts_q, parts_d;
  logic            accept, done, cls;
  logic [7:0]      b;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.text_byte;

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    cso_d        = cso_q;
    cso_cur      = cso_q;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    acc_new      = acc_q;
    run_d        = run_q;
    seen_d       = seen_q;
    parts_d      = parts_q;
    done         = 1'b0;
    cls          = 1'b0;
    evt_o        = '0;

    if (bytes_left_q == 2'd0) begin
      cso_cur = bytes_seen_q;
      cso_d   = bytes_seen_q;
      if (!b[7]) begin
        done = 1'b1;
      end else if (!b[5]) begin
        acc_d        = {16'd0, b[4:0]};
        bytes_left_d = 2'd1;
      end else if (!b[4]) begin
        acc_d        = {17'd0, b[3:0]};
        bytes_left_d = 2'd2;
      end else begin
        acc_d        = {18'd0, b[2:0]};
        bytes_left_d = 2'd3;
      end
    end else begin
      acc_new      = {acc_q[14:0], b[5:0]};
      acc_d        = acc_new;
      bytes_left_d = bytes_left_q - 2'd1;
      if (bytes_left_q == 2'd1) begin
        done = 1'b1;
        cls  = ues_pkg::classify_cp(acc_new, run_q);
      end
    end

    bs_new       = (bytes_seen_q < MaxCnt) ? bytes_seen_q + CntW'(1) : bytes_seen_q;
    bytes_seen_d = bs_new;

    // truncated sequence at end of text
    if (!done && in_i.final_byte) begin
      done = 1'b1;
      cls  = 1'b0;
    end

    if (done) begin
      if (!seen_q) begin
        evt_o.part_valid  = 1'b1;
        evt_o.part_offset = 16'd0;
        evt_o.part_emoji  = cls;
        evt_o.part_number = 16'd0;
        parts_d           = 16'd1;
        run_d             = cls;
        seen_d            = 1'b1;
      end else if (cls != run_q) begin
        evt_o.part_valid  = 1'b1;
        evt_o.part_offset = sat16(cso_cur);
        evt_o.part_emoji  = cls;
        evt_o.part_number = parts_q;
        parts_d           = (parts_q != 16'hFFFF) ? parts_q + 16'd1 : parts_q;
        run_d             = cls;
      end
    end

    if (in_i.final_byte) begin
      evt_o.end_valid  = 1'b1;
      evt_o.end_offset = sat16(bs_new);
      evt_o.end_number = parts_d;
      bytes_seen_d     = '0;
      cso_d            = '0;
      bytes_left_d     = 2'd0;
      acc_d            = '0;
      run_d            = 1'b0;
      seen_d           = 1'b0;
      parts_d          = 16'd0;
    end
  end

  assign push_o = accept && (evt_o.part_valid || evt_o.end_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      cso_q        <= '0;
      bytes_left_q <= 2'd0;
      acc_q        <= '0;
      run_q        <= 1'b0;
      seen_q       <= 1'b0;
      parts_q      <= 16'd0;
    end else if (accept) begin
      bytes_seen_q <= bytes_seen_d;
      cso_q        <= cso_d;
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      run_q        <= run_d;
      seen_q       <= seen_d;
      parts_q      <= parts_d;
    end
  end

  a_first_part_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && evt_o.part_valid && !seen_q |-> evt_o.part_number == 16'd0)
    else $error("first part not numbered zero");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.final_byte |=> bytes_left_q == 2'd0 && !seen_q && parts_q == 16'd0)
    else $error("state not cleared after end of text");

endmodule

[src/ues_queue.sv]
module ues_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ues_pkg::event_t data_i,
  input  logic            pop_i,
  output ues_pkg::event_t data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  ues_pkg::event_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

[src/ues_back.sv]
module ues_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  ues_out_if.source       out_o,
  input  ues_pkg::event_t head_i,
  input  logic            empty_i,
  output logic            pop_o
);

  logic        valid_q, valid_d, phase_q, phase_d, load, sel_end;
  logic        kind_q, emoji_q, last_q;
  logic [15:0] off_q, num_q;

  assign load    = (!valid_q || out_o.ready) && !empty_i;
  assign sel_end = phase_q || !head_i.part_valid;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (!sel_end && head_i.end_valid) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= pop_o;
      if (sel_end) begin
        kind_q  <= ues_pkg::RECORD_END;
        off_q   <= head_i.end_offset;
        emoji_q <= 1'b0;
        num_q   <= head_i.end_number;
      end else begin
        kind_q  <= ues_pkg::RECORD_PART;
        off_q   <= head_i.part_offset;
        emoji_q <= head_i.part_emoji;
        num_q   <= head_i.part_number;
      end
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.record_kind = kind_q;
  assign out_o.byte_offset = off_q;
  assign out_o.part_emoji  = emoji_q;
  assign out_o.part_number = num_q;
  assign out_o.last_of_run = last_q;

  a_phase_holds_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !empty_i && head_i.end_valid)
    else $error("second record pending without queued entry");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == ues_pkg::RECORD_END |-> last_q)
    else $error("end record not marked last");

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_ITEMS     = 1250;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_PAIRS       = 40;
  localparam int SINGLE_COUNT     = 22;
  localparam int SPAN_COUNT       = 13;
  localparam int REPORT_LINES     = 40;

  localparam logic [20:0] JOINER_CP   = 21'h0200D;
  localparam logic [20:0] TEXT_VS_CP  = 21'h0FE0E;
  localparam logic [20:0] EMOJI_VS_CP = 21'h0FE0F;

  typedef struct packed {
    logic        rec_kind;
    logic [15:0] rec_offset;
    logic        rec_emoji;
    logic [15:0] rec_number;
    logic        rec_last;
  } record_t;

  typedef struct {
    logic [7:0] text_byte;
    logic       final_byte;
    bit         typed;
    int         count;
    record_t    first;
    record_t    second;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ues_in_if  in_if ();
  ues_out_if out_if ();

  utf8_emoji_run_segmenter_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // segmenter state mirror
  logic [15:0] bytes_count;
  logic [15:0] char_start;
  logic [1:0]  cont_left;
  logic [20:0] code_acc;
  logic        in_emoji_run;
  logic        have_part;
  logic [15:0] part_total;

  record_t     expected_records[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  text_buf[$];
  record_t     want;
  int          mismatch_count;
  int          cycle_count;
  bit          src_idle_en;
  bit          snk_idle_en;
  bit          long_hold_req;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_emoji_run_segmenter_core: mismatch");
      $finish;
    end
  end

  function automatic logic [20:0] single_cp(input int k);
    case (k)
      0:  return 21'h000A9;
      1:  return 21'h000AE;
      2:  return 21'h0203C;
      3:  return 21'h02049;
      4:  return 21'h020E3;
      5:  return 21'h02122;
      6:  return 21'h02139;
      7:  return 21'h0231A;
      8:  return 21'h0231B;
      9:  return 21'h02328;
      10: return 21'h023CF;
      11: return 21'h024C2;
      12: return 21'h025AA;
      13: return 21'h025AB;
      14: return 21'h025B6;
      15: return 21'h025C0;
      16: return 21'h02934;
      17: return 21'h02935;
      18: return 21'h03030;
      19: return 21'h0303D;
      20: return 21'h03297;
      default: return 21'h03299;
    endcase
  endfunction

  function automatic logic [20:0] span_lo(input int k);
    case (k)
      0:  return 21'h02194;
      1:  return 21'h021A9;
      2:  return 21'h023E9;
      3:  return 21'h023F8;
      4:  return 21'h025FB;
      5:  return 21'h02600;
      6:  return 21'h02B00;
      7:  return 21'h1F000;
      8:  return 21'h1F0A0;
      9:  return 21'h1F100;
      10: return 21'h1F600;
      11: return 21'h1F900;
      default: return 21'h1F980;
    endcase
  endfunction

  function automatic logic [20:0] span_hi(input int k);
    case (k)
      0:  return 21'h02199;
      1:  return 21'h021AA;
      2:  return 21'h023F3;
      3:  return 21'h023FA;
      4:  return 21'h025FE;
      5:  return 21'h027EF;
      6:  return 21'h02BFF;
      7:  return 21'h1F02F;
      8:  return 21'h1F0FF;
      9:  return 21'h1F64F;
      10: return 21'h1F6FF;
      11: return 21'h1F9FF;
      default: return 21'h1F9E0;
    endcase
  endfunction

  function automatic logic pictograph(input logic [20:0] cp, input logic run_emoji);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < SINGLE_COUNT; k++) begin
      if (cp == single_cp(k)) hit = 1'b1;
    end
    for (int k = 0; k < SPAN_COUNT; k++) begin
      if (cp >= span_lo(k) && cp <= span_hi(k)) hit = 1'b1;
    end
    if (run_emoji && (cp == JOINER_CP || cp == TEXT_VS_CP || cp == EMOJI_VS_CP)) hit = 1'b1;
    return hit;
  endfunction

  function automatic record_t make_rec(input logic kind, input logic [15:0] offset,
                                       input logic emoji, input logic [15:0] number,
                                       input logic last);
    record_t r;
    r.rec_kind   = kind;
    r.rec_offset = offset;
    r.rec_emoji  = emoji;
    r.rec_number = number;
    r.rec_last   = last;
    return r;
  endfunction

  function automatic void clear_text_state();
    bytes_count  = 16'd0;
    char_start   = 16'd0;
    cont_left    = 2'd0;
    code_acc     = 21'd0;
    in_emoji_run = 1'b0;
    have_part    = 1'b0;
    part_total   = 16'd0;
  endfunction

  // records caused by one byte, in order; returns how many
  function automatic int segment_byte(input logic [7:0] b, input logic fin,
                                      output record_t r0, output record_t r1);
    logic    done;
    logic    emo;
    int      n;
    record_t end_rec;
    done = 1'b0;
    emo  = 1'b0;
    n    = 0;
    r0   = '0;
    r1   = '0;
    if (cont_left == 2'd0) begin
      char_start = bytes_count;
      if (!b[7]) begin
        done = 1'b1;
      end else if (!b[5]) begin
        code_acc  = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (!b[4]) begin
        code_acc  = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else begin
        code_acc  = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end
    end else begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        done = 1'b1;
        emo  = pictograph(code_acc, in_emoji_run);
      end
    end
    if (bytes_count != 16'hFFFF) bytes_count = bytes_count + 16'd1;
    // cut-off sequence counts as plain text
    if (!done && fin) done = 1'b1;
    if (done) begin
      if (!have_part) begin
        have_part    = 1'b1;
        in_emoji_run = emo;
        r0           = make_rec(ues_pkg::RECORD_PART, 16'd0, emo, 16'd0, 1'b0);
        part_total   = 16'd1;
        n            = 1;
      end else if (emo != in_emoji_run) begin
        in_emoji_run = emo;
        r0           = make_rec(ues_pkg::RECORD_PART, char_start, emo, part_total, 1'b0);
        if (part_total != 16'hFFFF) part_total = part_total + 16'd1;
        n            = 1;
      end
    end
    if (fin) begin
      end_rec = make_rec(ues_pkg::RECORD_END, bytes_count, 1'b0, part_total, 1'b1);
      if (n == 0) r0 = end_rec;
      else r1 = end_rec;
      n = n + 1;
      clear_text_state();
    end else if (n == 1) begin
      r0.rec_last = 1'b1;
    end
    return n;
  endfunction

  task automatic store_records(input int n, input record_t r0, input record_t r1);
    if (n > 0) expected_records.insert(expected_records.size(), r0);
    if (n > 1) expected_records.insert(expected_records.size(), r1);
  endtask

  task automatic report(input string field, input int unsigned exp_val,
                        input int unsigned got_val);
    if (mismatch_count < REPORT_LINES)
      $display("%0t: %s expected %0d got %0d", $time, field, exp_val, got_val);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_if.valid      <= 1'b1;
    in_if.text_byte  <= b;
    in_if.final_byte <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic fin);
    record_t r0;
    record_t r1;
    int      n;
    n = segment_byte(b, fin, r0, r1);
    store_records(n, r0, r1);
    send_byte(b, fin);
    maybe_gap();
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin, input bit typed,
                         input int count, input record_t first, input record_t second);
    stim_row_t row;
    row.text_byte  = b;
    row.final_byte = fin;
    row.typed      = typed;
    row.count      = count;
    row.first      = first;
    row.second     = second;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic append_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_buf.insert(text_buf.size(), {1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      text_buf.insert(text_buf.size(), {3'b110, cp[10:6]});
      text_buf.insert(text_buf.size(), {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_buf.insert(text_buf.size(), {4'b1110, cp[15:12]});
      text_buf.insert(text_buf.size(), {2'b10, cp[11:6]});
      text_buf.insert(text_buf.size(), {2'b10, cp[5:0]});
    end else begin
      text_buf.insert(text_buf.size(), {5'b11110, cp[20:18]});
      text_buf.insert(text_buf.size(), {2'b10, cp[17:12]});
      text_buf.insert(text_buf.size(), {2'b10, cp[11:6]});
      text_buf.insert(text_buf.size(), {2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [20:0] pick_pictograph();
    int          k;
    logic [20:0] lo;
    logic [20:0] hi;
    if ($urandom_range(0, 2) == 0) return single_cp($urandom_range(0, SINGLE_COUNT - 1));
    k  = $urandom_range(0, SPAN_COUNT - 1);
    lo = span_lo(k);
    hi = span_hi(k);
    case ($urandom_range(0, 4))
      0: return lo - 21'd1;
      1: return lo;
      2: return hi;
      3: return hi + 21'd1;
      default: return lo + 21'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  task automatic build_text();
    int kind;
    text_buf.delete();
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(0, 15);
      if (kind <= 3) begin
        append_cp(21'($urandom_range(0, 8'h7F)));
      end else if (kind <= 8) begin
        append_cp(pick_pictograph());
      end else if (kind <= 10) begin
        case ($urandom_range(0, 2))
          0: append_cp(JOINER_CP);
          1: append_cp(TEXT_VS_CP);
          default: append_cp(EMOJI_VS_CP);
        endcase
      end else if (kind == 11) begin
        append_cp(21'($urandom_range(21'h80, 21'h7FF)));
      end else if (kind == 12) begin
        append_cp(21'($urandom_range(21'h800, 21'hFFFF)));
      end else if (kind == 13) begin
        append_cp(21'($urandom_range(21'h10000, 21'h1FFFFF)));
      end else begin
        text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_records.size() == 0) begin
        report("record with nothing pending, record_kind", 0, out_if.record_kind);
      end else begin
        want = expected_records.pop_front();
        if (out_if.record_kind != want.rec_kind)
          report("record_kind", want.rec_kind, out_if.record_kind);
        if (out_if.byte_offset != want.rec_offset)
          report("byte_offset", want.rec_offset, out_if.byte_offset);
        if (out_if.part_emoji != want.rec_emoji)
          report("part_emoji", want.rec_emoji, out_if.part_emoji);
        if (out_if.part_number != want.rec_number)
          report("part_number", want.rec_number, out_if.part_number);
        if (out_if.last_of_run != want.rec_last)
          report("last_of_run", want.rec_last, out_if.last_of_run);
      end
    end
  end

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t row;
    record_t   r0;
    record_t   r1;
    int        n;
    int        fin_at;
    int        items_sent;
    bit        hold_done;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.text_byte  = 8'd0;
    in_if.final_byte = 1'b0;
    cycle_count      = 0;
    mismatch_count   = 0;
    src_idle_en      = 1'b1;
    snk_idle_en      = 1'b1;
    long_hold_req    = 1'b0;
    items_sent       = 0;
    hold_done        = 1'b0;
    clear_text_state();

    // one-byte strings straight after reset
    add_row(8'h41, 1'b1, 1'b1, 2, make_rec(ues_pkg::RECORD_PART, 16'd0, 1'b0, 16'd0, 1'b0),
            make_rec(ues_pkg::RECORD_END, 16'd1, 1'b0, 16'd1, 1'b1));
    add_row(8'h00, 1'b1, 1'b1, 2, make_rec(ues_pkg::RECORD_PART, 16'd0, 1'b0, 16'd0, 1'b0),
            make_rec(ues_pkg::RECORD_END, 16'd1, 1'b0, 16'd1, 1'b1));
    // all-ones four-byte sequence, then DEL
    add_row(8'hFF, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hBF, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hBF, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hBF, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h7F, 1'b1, 1'b0, 0, '0, '0);
    // emoji, variation selector inside the run, then text
    add_row(8'hF0, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h9F, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h98, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h80, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hEF, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hB8, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h8F, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h61, 1'b1, 1'b0, 0, '0, '0);
    // joiner as first character, then an emoji
    add_row(8'hE2, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h80, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h8D, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hC2, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hA9, 1'b1, 1'b0, 0, '0, '0);
    // emoji cut short by the end of text, then a complete one
    add_row(8'hE2, 1'b0, 1'b1, 0, '0, '0);
    add_row(8'h98, 1'b1, 1'b1, 2, make_rec(ues_pkg::RECORD_PART, 16'd0, 1'b0, 16'd0, 1'b0),
            make_rec(ues_pkg::RECORD_END, 16'd2, 1'b0, 16'd1, 1'b1));
    add_row(8'hC2, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'hAE, 1'b1, 1'b0, 0, '0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      n = segment_byte(row.text_byte, row.final_byte, r0, r1);
      if (row.typed) store_records(row.count, row.first, row.second);
      else store_records(n, r0, r1);
      send_byte(row.text_byte, row.final_byte);
      maybe_gap();
    end

    while (items_sent < RANDOM_ITEMS) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      if (!hold_done && items_sent >= 300) begin
        // sender keeps offering while the receiver holds off
        src_idle_en   = 1'b0;
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      build_text();
      if ($urandom_range(0, 4) == 0) fin_at = $urandom_range(0, text_buf.size() - 1);
      else fin_at = text_buf.size() - 1;
      for (int i = 0; i <= fin_at; i++) begin
        feed_byte(text_buf[i], i == fin_at);
        items_sent++;
      end
    end

    // closing stretch, back to back on both sides
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int i = 0; i < LONG_PAIRS; i++) begin
      feed_byte(8'h41, 1'b0);
      feed_byte(8'hC2, 1'b0);
      feed_byte(8'hA9, i == LONG_PAIRS - 1);
    end
    in_if.valid <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("utf8_emoji_run_segmenter_core: match");
    end else begin
      $display("utf8_emoji_run_segmenter_core: mismatch");
    end
    $finish;
  end

endmodule
